[rtl/tnf_pkg.sv]
// tnf_pkg: widths, reset value and the shared type of the thresholded normal filter.
// No dependencies; every other file of the filter depends on this package.
package tnf_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned FRAC_BITS = 14;

  // accumulation datapath
  localparam int unsigned ACC_W  = 34;                        // dot product and d
  localparam int unsigned DT_W   = ACC_W - 1 - FRAC_BITS;     // d >> FRAC_BITS, d > 0
  localparam int unsigned W_W    = 2 * DT_W - FRAC_BITS;      // weight
  localparam int unsigned SUM_W  = 48;

  // shared multiplier
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // normalize datapath: largest magnitude lands with its top bit at MAG_W-1
  localparam int unsigned MAG_W  = 30;
  localparam int unsigned SS_W   = 2 * MAG_W + 2;             // sum of three squares
  localparam int unsigned LEN_W  = MAG_W + 1;                 // floor(sqrt(ss))
  localparam int unsigned NUM_W  = MAG_W + FRAC_BITS + 1;     // rounded dividend

  localparam logic signed [DATA_W-1:0] SIGMA_RST = 16'sd6554;
  localparam logic [DATA_W-1:0] OUT_POS_MAX = 16'h7FFF;
  localparam logic [DATA_W-1:0] OUT_NEG_MAX = 16'h8000;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

[rtl/tnf_if.sv]
// tnf_in_if / tnf_out_if: valid/ready channels of the thresholded normal filter.
// Depends on tnf_pkg for the field type.
interface tnf_in_if;
  logic          valid;
  logic          ready;
  tnf_pkg::data_t center_x;
  tnf_pkg::data_t center_y;
  tnf_pkg::data_t center_z;
  tnf_pkg::data_t nbr_x;
  tnf_pkg::data_t nbr_y;
  tnf_pkg::data_t nbr_z;
  logic          is_last;

  modport source (output valid, center_x, center_y, center_z, nbr_x, nbr_y, nbr_z, is_last,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, nbr_x, nbr_y, nbr_z, is_last,
                  output ready);
endinterface

interface tnf_out_if;
  logic          valid;
  logic          ready;
  tnf_pkg::data_t filtered_x;
  tnf_pkg::data_t filtered_y;
  tnf_pkg::data_t filtered_z;

  modport source (output valid, filtered_x, filtered_y, filtered_z, input ready);
  modport sink   (input valid, filtered_x, filtered_y, filtered_z, output ready);
endinterface

[rtl/tnf_mul.sv]
// tnf_mul: shared signed multiplier with a registered product.
// Depends on tnf_pkg for operand and product widths.
module tnf_mul (
  input  logic                               clk_i,
  input  logic signed [tnf_pkg::MUL_W-1:0]   a_i,
  input  logic signed [tnf_pkg::MUL_W-1:0]   b_i,
  output logic signed [tnf_pkg::PROD_W-1:0]  p_o
);
  import tnf_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[rtl/tnf_sqrt.sv]
// tnf_sqrt: bit-pair integer square root, one result bit per cycle.
// Depends on tnf_pkg for the operand and root widths.
module tnf_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tnf_pkg::SS_W-1:0]         x_i,
  output logic                             done_o,
  output logic [tnf_pkg::LEN_W-1:0]        root_o
);
  import tnf_pkg::*;

  logic [SS_W-1:0] x_q, res_q, bit_q;
  logic            busy_q, done_q;
  logic [SS_W-1:0] trial;
  logic            take;

  assign trial = res_q + bit_q;
  assign take  = (x_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= SS_W'(1) << (SS_W - 2);
    end else if (busy_q) begin
      if (take) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[LEN_W-1:0];

endmodule

[rtl/tnf_div.sv]
// tnf_div: restoring divider, one quotient bit per cycle.
// Depends on tnf_pkg for the dividend, divisor and quotient widths.
module tnf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tnf_pkg::NUM_W-1:0]    num_i,
  input  logic [tnf_pkg::LEN_W-1:0]    den_i,
  output logic                         done_o,
  output logic [tnf_pkg::NUM_W-1:0]    quo_o
);
  import tnf_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [LEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [LEN_W:0]   trial;
  logic             take;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign take  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], take};
      rem_q <= take ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

[rtl/thresholded_normal_filter.sv]
// thresholded_normal_filter: top level, sequencer and datapath registers of the filter.
// Depends on tnf_pkg, tnf_if (channels), tnf_mul, tnf_sqrt and tnf_div.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+---------------------------------------------
//   in_i    | in  | valid / ready    | center_x/y/z, nbr_x/y/z, is_last
//   out_o   | out | valid / ready    | filtered_x/y/z
//   cfg     | in  | cfg_we_i         | cfg_data_i (sigma, Q2.14)
//
// An item ends after the dot product when its threshold test fails and goes on to add to
// the sum when it passes; the one shared multiplier carries the dot product, the weight
// and the three weighted terms. A last item adds the normalize pass: one-bit shifts, the
// squares on the multiplier, the root and the three divides. The result sits in an output
// register, so the next run starts while it waits for transfer; only a second result
// stalls behind it.
// Reset clears the sums, the threshold (to 0.4) and the channel state; no clearing pass.
module thresholded_normal_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  tnf_pkg::data_t  cfg_data_i,
  tnf_in_if.sink          in_i,
  tnf_out_if.source       out_o
);
  import tnf_pkg::*;

  localparam int unsigned NST = 21;

  typedef enum logic [NST-1:0] {
    ST_IDLE  = NST'(1) << 0,
    ST_DOT0  = NST'(1) << 1,
    ST_DOT1  = NST'(1) << 2,
    ST_DOT2  = NST'(1) << 3,
    ST_DOT3  = NST'(1) << 4,
    ST_WSQ   = NST'(1) << 5,
    ST_WGET  = NST'(1) << 6,
    ST_ACCX  = NST'(1) << 7,
    ST_ACCY  = NST'(1) << 8,
    ST_ACCZ  = NST'(1) << 9,
    ST_ACCE  = NST'(1) << 10,
    ST_NINIT = NST'(1) << 11,
    ST_SHIFT = NST'(1) << 12,
    ST_SQ0   = NST'(1) << 13,
    ST_SQ1   = NST'(1) << 14,
    ST_SQ2   = NST'(1) << 15,
    ST_SQ3   = NST'(1) << 16,
    ST_ROOT  = NST'(1) << 17,
    ST_DIV   = NST'(1) << 18,
    ST_PUT   = NST'(1) << 19,
    ST_SPARE = NST'(1) << 20
  } state_e;

  // add a weighted term to a sum, clamp to the signed sum range
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                       input logic signed [SUM_W-1:0] t);
    logic signed [SUM_W:0] r;
    r = {s[SUM_W-1], s} + {t[SUM_W-1], t};
    if (r[SUM_W] != r[SUM_W-1]) begin
      sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = r[SUM_W-1:0];
    end
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] s);
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
  endfunction

  // clamp a quotient magnitude and apply the sign
  function automatic data_t emit(input logic [NUM_W-1:0] q, input logic neg);
    if (neg) begin
      emit = (q > NUM_W'(OUT_NEG_MAX)) ? OUT_NEG_MAX : DATA_W'(~q + NUM_W'(1));
    end else begin
      emit = (q > NUM_W'(OUT_POS_MAX)) ? OUT_POS_MAX : q[DATA_W-1:0];
    end
  endfunction

  state_e state_q, state_d;

  data_t                   sigma_q;
  data_t                   cx_q, cy_q, cz_q, nx_q, ny_q, nz_q;
  logic                    last_q;
  logic signed [ACC_W-1:0] acc_q, d_q;
  logic [W_W-1:0]          w_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic [SUM_W-1:0]        mag_q [3];
  logic [SUM_W-1:0]        mm_q;
  logic [2:0]              sgn_q;
  logic [SS_W-1:0]         ss_q;
  logic [1:0]              k_q;
  data_t                   res_q [3];
  data_t                   fx_q, fy_q, fz_q;
  logic                    out_valid_q;

  logic                     in_fire, out_fire, d_pos, normed, load_out;
  logic [DT_W-1:0]          dt;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         mag_c [3];
  logic [SUM_W-1:0]         mm_c;
  logic                     sq_start, sq_done, dv_start, dv_done;
  logic [1:0]               dv_sel;
  logic [LEN_W-1:0]         root;
  logic [NUM_W-1:0]         dv_num, quo;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign d_pos    = !d_q[ACC_W-1] && (d_q != '0);
  assign dt       = d_q[ACC_W-2:FRAC_BITS];
  assign normed   = (mm_q[SUM_W-1:MAG_W] == '0) && mm_q[MAG_W-1];
  assign load_out = (state_q == ST_PUT) && !out_valid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = mag(sum_q[i]);
    end
    mm_c = mag_c[0];
    if (mag_c[1] > mm_c) mm_c = mag_c[1];
    if (mag_c[2] > mm_c) mm_c = mag_c[2];
  end

  // rounded dividend: (mag << FRAC_BITS) + len / 2
  assign dv_num = (NUM_W'(mag_q[dv_sel][MAG_W-1:0]) << FRAC_BITS) + NUM_W'(root >> 1);

  // sequencer: steer the shared multiplier and start the root and divide units
  always_comb begin
    state_d  = state_q;
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    dv_sel   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_DOT0;
      end
      ST_DOT0: begin
        mul_a = MUL_W'(cx_q); mul_b = MUL_W'(nx_q); state_d = ST_DOT1;
      end
      ST_DOT1: begin
        mul_a = MUL_W'(cy_q); mul_b = MUL_W'(ny_q); state_d = ST_DOT2;
      end
      ST_DOT2: begin
        mul_a = MUL_W'(cz_q); mul_b = MUL_W'(nz_q); state_d = ST_DOT3;
      end
      ST_DOT3: state_d = ST_WSQ;
      ST_WSQ: begin
        if (d_pos) begin
          mul_a   = MUL_W'(dt);
          mul_b   = MUL_W'(dt);
          state_d = ST_WGET;
        end else begin
          state_d = last_q ? ST_NINIT : ST_IDLE;
        end
      end
      ST_WGET: state_d = ST_ACCX;
      ST_ACCX: begin
        mul_a = MUL_W'(nx_q); mul_b = MUL_W'(w_q); state_d = ST_ACCY;
      end
      ST_ACCY: begin
        mul_a = MUL_W'(ny_q); mul_b = MUL_W'(w_q); state_d = ST_ACCZ;
      end
      ST_ACCZ: begin
        mul_a = MUL_W'(nz_q); mul_b = MUL_W'(w_q); state_d = ST_ACCE;
      end
      ST_ACCE: state_d = last_q ? ST_NINIT : ST_IDLE;
      ST_NINIT: state_d = (mm_c == '0) ? ST_PUT : ST_SHIFT;
      ST_SHIFT: begin
        if (normed) state_d = ST_SQ0;
      end
      ST_SQ0: begin
        mul_a = MUL_W'(mag_q[0][MAG_W-1:0]); mul_b = MUL_W'(mag_q[0][MAG_W-1:0]);
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a = MUL_W'(mag_q[1][MAG_W-1:0]); mul_b = MUL_W'(mag_q[1][MAG_W-1:0]);
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        mul_a = MUL_W'(mag_q[2][MAG_W-1:0]); mul_b = MUL_W'(mag_q[2][MAG_W-1:0]);
        state_d = ST_SQ3;
      end
      ST_SQ3: begin
        sq_start = 1'b1;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          dv_start = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          if (k_q == 2'd2) begin
            state_d = ST_PUT;
          end else begin
            dv_start = 1'b1;
            dv_sel   = k_q + 2'd1;
          end
        end
      end
      ST_PUT: begin
        if (!out_valid_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sigma_q     <= SIGMA_RST;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) sigma_q <= cfg_data_i;
      if (out_fire) out_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      if ((state_q == ST_ROOT) && sq_done) k_q <= '0;
      if ((state_q == ST_DIV) && dv_done) k_q <= k_q + 2'd1;
      // sums take the weighted terms one product behind the multiplier
      if (state_q == ST_ACCY) sum_q[0] <= sat_add(sum_q[0], prod[SUM_W-1:0]);
      if (state_q == ST_ACCZ) sum_q[1] <= sat_add(sum_q[1], prod[SUM_W-1:0]);
      if (state_q == ST_ACCE) sum_q[2] <= sat_add(sum_q[2], prod[SUM_W-1:0]);
      if (state_q == ST_NINIT) begin
        for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cx_q   <= in_i.center_x;
      cy_q   <= in_i.center_y;
      cz_q   <= in_i.center_z;
      nx_q   <= in_i.nbr_x;
      ny_q   <= in_i.nbr_y;
      nz_q   <= in_i.nbr_z;
      last_q <= in_i.is_last;
    end
    if (state_q == ST_DOT1) acc_q <= prod[ACC_W-1:0];
    if (state_q == ST_DOT2) acc_q <= acc_q + prod[ACC_W-1:0];
    if (state_q == ST_DOT3) begin
      d_q <= acc_q + prod[ACC_W-1:0] - (ACC_W'(sigma_q) <<< FRAC_BITS);
    end
    if (state_q == ST_WGET) w_q <= prod[FRAC_BITS +: W_W];
    if (state_q == ST_NINIT) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= mag_c[i];
        sgn_q[i] <= sum_q[i][SUM_W-1];
        res_q[i] <= '0;
      end
      mm_q <= mm_c;
    end
    // one-bit steps drop low bits on the right the same as one long shift
    if ((state_q == ST_SHIFT) && !normed) begin
      if (mm_q[SUM_W-1:MAG_W] != '0) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        mm_q <= mm_q >> 1;
      end else begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        mm_q <= mm_q << 1;
      end
    end
    if (state_q == ST_SQ1) ss_q <= prod[SS_W-1:0];
    if (state_q == ST_SQ2) ss_q <= ss_q + prod[SS_W-1:0];
    if ((state_q == ST_DIV) && dv_done) res_q[k_q] <= emit(quo, sgn_q[k_q]);
    if (load_out) begin
      fx_q <= res_q[0];
      fy_q <= res_q[1];
      fz_q <= res_q[2];
    end
  end

  tnf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tnf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (ss_q + prod[SS_W-1:0]),
    .done_o  (sq_done),
    .root_o  (root)
  );

  tnf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (root),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.filtered_x = fx_q;
  assign out_o.filtered_y = fy_q;
  assign out_o.filtered_z = fz_q;

`ifndef ASSERT_OFF
  // an accepted item always starts the dot product next
  a_start_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_DOT0)
    else $error("accepted item did not start the dot product");

  // the sums are cleared once the run has been handed to the normalize pass
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUT |-> sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0)
    else $error("sums not cleared at end of run");

  // squares are formed only on normalized magnitudes
  a_normed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQ0 |-> mm_q[MAG_W-1] && mm_q[SUM_W-1:MAG_W] == '0)
    else $error("magnitudes not normalized");

  // the divisor is never zero
  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> root != '0)
    else $error("divide started with zero length");
`endif

endmodule

[bench/tb_thresholded_normal_filter.sv]
// Testbench for the thresholded normal filter: directed and random neighbor runs,
// checked against a predictor of the weighted sum and normalize. Depends on tnf_pkg, tnf_if and the filter.
module tb_thresholded_normal_filter;
  import tnf_pkg::*;

  typedef struct packed {
    data_t cx, cy, cz, nx, ny, nz;
    logic  last;
  } nbr_item_t;

  typedef struct packed {
    data_t fx, fy, fz;
  } normal_t;

  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int     CYCLE_LIMIT = 2_000_000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i = 1'b0;
  data_t cfg_data_i = '0;

  tnf_in_if  in_ch ();
  tnf_out_if out_ch ();

  thresholded_normal_filter i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint  acc_x, acc_y, acc_z;
  longint  thr_sigma;
  normal_t normals_due[$];

  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned item_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_rx = 1'b0;   // forces a long receiver hold-off

  function automatic longint sat48(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic data_t scale_comp(longint s, longint unsigned m, longint unsigned len);
    longint unsigned q = ((m << FRAC_BITS) + (len >> 1)) / len;
    if (s < 0) begin
      if (q > 32768) q = 32768;
      return data_t'(-q);
    end
    if (q > 32767) q = 32767;
    return data_t'(q);
  endfunction

  // Accumulate one neighbor; on a last item queue the normalized sum.
  function automatic void weigh_neighbor(nbr_item_t it);
    longint dotp, d, w;
    longint unsigned dt, mx, my, mz, mm, len;
    int p;
    normal_t r;
    dotp = longint'(it.cx) * it.nx + longint'(it.cy) * it.ny + longint'(it.cz) * it.nz;
    d = dotp - (thr_sigma <<< FRAC_BITS);
    if (d > 0) begin
      dt = longint'(d) >> FRAC_BITS;
      w = longint'((dt * dt) >> FRAC_BITS);
      acc_x = sat48(acc_x + longint'(it.nx) * w);
      acc_y = sat48(acc_y + longint'(it.ny) * w);
      acc_z = sat48(acc_z + longint'(it.nz) * w);
    end
    if (!it.last) return;
    mx = acc_x < 0 ? -acc_x : acc_x;
    my = acc_y < 0 ? -acc_y : acc_y;
    mz = acc_z < 0 ? -acc_z : acc_z;
    mm = mx;
    if (my > mm) mm = my;
    if (mz > mm) mm = mz;
    if (mm == 0) begin
      r = '0;
    end else begin
      p = 0;
      while (p < 63 && (mm >> (p + 1)) != 0) p++;
      if (p > 29) begin
        mx >>= (p - 29); my >>= (p - 29); mz >>= (p - 29);
      end else begin
        mx <<= (29 - p); my <<= (29 - p); mz <<= (29 - p);
      end
      len = root64(mx * mx + my * my + mz * mz);
      r.fx = scale_comp(acc_x, mx, len);
      r.fy = scale_comp(acc_y, my, len);
      r.fz = scale_comp(acc_z, mz, len);
    end
    normals_due.push_back(r);
    acc_x = 0; acc_y = 0; acc_z = 0;
  endfunction

  function automatic int gap_len();
    int k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, normals_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, with an occasional forced hold-off.
  int unsigned rx_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_rx) begin
      out_ch.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      out_ch.ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (out_ch.ready && out_ch.valid) begin
      // after each transfer, drop ready, and now and then stall for a longer random gap
      rx_wait <= gap_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest expected normal.
  always @(posedge clk_i) begin
    normal_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.filtered_x, out_ch.filtered_y, out_ch.filtered_z};
      res_cnt++;
      if (normals_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %0d %0d %0d", got.fx, got.fy, got.fz);
      end else begin
        want = normals_due.pop_front();
        if (got != want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d: expected %0d %0d %0d, got %0d %0d %0d", res_cnt,
                     want.fx, want.fy, want.fz, got.fx, got.fy, got.fz);
        end
      end
    end
  end

  // Offer one item and hold it until transfer; predict at acceptance.
  task automatic send_item(nbr_item_t it, bit no_gap = 1'b0);
    int g = no_gap ? 0 : gap_len();
    // valid goes low between items
    repeat (g + 1) @(posedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.center_x <= it.cx; in_ch.center_y <= it.cy; in_ch.center_z <= it.cz;
    in_ch.nbr_x    <= it.nx; in_ch.nbr_y    <= it.ny; in_ch.nbr_z    <= it.nz;
    in_ch.is_last  <= it.last;
    do @(posedge clk_i); while (!in_ch.ready);
    weigh_neighbor(it);
    item_cnt++;
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (normals_due.size() != 0) @(posedge clk_i);
    // let any item still in the datapath finish after the last result
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_sigma(data_t v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_sigma = v;
  endtask

  function automatic data_t rand_unit();
    int k = $urandom_range(0, 9);
    if (k == 0) return data_t'($urandom);   // out of range, all bits
    if (k == 1) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return data_t'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Neighbor near the center so the threshold usually passes.
  function automatic nbr_item_t near_item(data_t cx, data_t cy, data_t cz, bit last);
    nbr_item_t it;
    it.cx = cx; it.cy = cy; it.cz = cz;
    it.nx = data_t'(cx + $signed($urandom_range(0, 4000)) - 2000);
    it.ny = data_t'(cy + $signed($urandom_range(0, 4000)) - 2000);
    it.nz = data_t'(cz + $signed($urandom_range(0, 4000)) - 2000);
    it.last = last;
    return it;
  endfunction

  task automatic send_run(int len, bit noisy);
    data_t cx = rand_unit(), cy = rand_unit(), cz = rand_unit();
    nbr_item_t it;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        it = {rand_unit(), rand_unit(), rand_unit(), rand_unit(), rand_unit(), rand_unit(),
              1'b0};
        it.last = (i == len - 1);
      end else begin
        it = near_item(cx, cy, cz, i == len - 1);
      end
      send_item(it);
    end
  endtask

  // Directed: extremes, threshold fail, zero sum, large sums, single-item run.
  task automatic test_directed();
    const data_t P = 16'sd16384;
    const data_t N = -16'sd16384;
    send_item('{P, 0, 0, P, 0, 0, 1'b1});              // aligned, one-item run
    send_item('{P, 0, 0, N, 0, 0, 1'b1});              // threshold fails: zero sum
    send_item('{0, P, 0, 0, P, 0, 1'b0});
    send_item('{0, P, 0, 0, 16'sd10000, 16'sd10000, 1'b0});
    send_item('{0, P, 0, 0, N, 0, 1'b1});              // mix of passed and failed
    send_item('{0, 0, N, 0, 0, N, 1'b1});              // negative result
    send_item('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0});
    send_item('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1});
    send_item('{16'sh9000, 16'sh9000, 16'sh9000, 16'sh9000, 16'sh9000, 16'sh7000, 1'b1});
    send_item('{16'sd9459, 16'sd9459, 16'sd9459, 16'sd9459, 16'sd9459, 16'sd9459, 1'b1});
    // build large sums from out-of-range vectors; they stay inside the saturation bound
    for (int i = 0; i < 8; i++)
      send_item('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  i == 7}, 1'b1);
    send_item('{0, 0, 0, 0, 0, 0, 1'b1});              // zero vectors
  endtask

  task automatic test_sigma_sweep();
    data_t sig[4] = '{-16'sd16384, 16'sd16384, 16'sd0, -16'sd1};
    foreach (sig[s]) begin
      write_sigma(sig[s]);
      repeat (20) send_run($urandom_range(1, 6), $urandom_range(0, 3) == 0);
    end
    write_sigma(SIGMA_RST);
  endtask

  // Receiver holds off while runs keep coming, then the sender waits for all.
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        // long enough for two runs to finish and stall the input
        repeat (1500) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (6) send_run(2, 1'b0);
    join
    while (normals_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random();
    while (item_cnt < 1500) begin
      if ($urandom_range(0, 4) == 0) send_run($urandom_range(1, 12), 1'b1);
      else send_run($urandom_range(1, 8), 1'b0);
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.center_x <= '0; in_ch.center_y <= '0; in_ch.center_z <= '0;
    in_ch.nbr_x <= '0; in_ch.nbr_y <= '0; in_ch.nbr_z <= '0;
    in_ch.is_last <= 1'b0;
    thr_sigma = SIGMA_RST;
    acc_x = 0; acc_y = 0; acc_z = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_sigma_sweep();
    test_backpressure();
    test_random();
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d neighbor items and %0d filtered normals over 5 thresholds",
             item_cnt, res_cnt);
    $display("including a long output stall and a full drain");
    if (err_cnt == 0 && normals_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, normals_due.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/tnf_pkg.sv
rtl/tnf_if.sv
rtl/tnf_mul.sv
rtl/tnf_sqrt.sv
rtl/tnf_div.sv
rtl/thresholded_normal_filter.sv
bench/tb_thresholded_normal_filter.sv
